// File: hdl/cicb_pkg.sv
package cicb_pkg;

  // Function codes of an input transaction.
  localparam logic [1:0] FUNC_EDGE   = 2'd0;
  localparam logic [1:0] FUNC_FINISH = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_SOURCE = 2'd0;
  localparam logic [1:0] KIND_COUNT  = 2'd1;
  localparam logic [1:0] KIND_DEGREE = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_ORDER      = 3'd1;
  localparam logic [2:0] ERR_DEST_RANGE = 3'd2;
  localparam logic [2:0] ERR_SRC_RANGE  = 3'd3;
  localparam logic [2:0] ERR_DEGREE_OVF = 3'd4;

  // One input transaction can cause at most this many results.
  localparam int NUM_SLOTS = 3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] edge_source;
    logic [31:0] edge_destination;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] vertex_index;
    logic [31:0] value;
    logic [16:0] run_length;
    logic [2:0]  err_code;
    logic        last;
  } out_item_t;

  // All results of one input transaction, in output order, with a mask of those present.
  typedef struct packed {
    logic [NUM_SLOTS-1:0]            mask;
    out_item_t [NUM_SLOTS-1:0]       slot;
  } bundle_t;

  // Builds one result; index and run length keep their low bits only.
  function automatic out_item_t make_result(input logic [1:0] kind, input logic [31:0] idx,
                                            input logic [31:0] val, input logic [31:0] run,
                                            input logic [2:0] err);
    out_item_t r;
    r.kind         = kind;
    r.vertex_index = idx[15:0];
    r.value        = val;
    r.run_length   = run[16:0];
    r.err_code     = err;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

// File: hdl/cicb_ram.sv
module cicb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/cicb_degree_mem.sv
module cicb_degree_mem #(
  parameter int MAX_VERTICES = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  output logic                              busy,
  input  logic                              rd_en,
  input  logic [$clog2(MAX_VERTICES)-1:0]   rd_addr,
  output logic [31:0]                       rd_data,
  input  logic                              wr_en,
  input  logic [$clog2(MAX_VERTICES)-1:0]   wr_addr,
  input  logic [31:0]                       wr_data
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [31:0]   ram_wr_data;
  logic [31:0]   ram_q;
  logic [AW-1:0] rd_addr_q;
  logic          byp_valid;
  logic [AW-1:0] byp_addr;
  logic [31:0]   byp_data;

  // Clearing sweep after reset: one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  assign busy = clearing;

  // The sweep owns the write port until it is done.
  always_comb begin
    if (clearing) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = wr_en;
      ram_wr_addr = wr_addr;
      ram_wr_data = wr_data;
    end
  end

  cicb_ram #(
    .WIDTH (32),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Remember the read address and the most recent write for forwarding.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (ram_wr_en) begin
      byp_addr <= ram_wr_addr;
      byp_data <= ram_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (ram_wr_en) begin
      byp_valid <= 1'b1;
    end
  end

  // A write landing on the same edge as the read is taken from the bypass register.
  assign rd_data = (byp_valid && byp_addr == rd_addr_q) ? byp_data : ram_q;

  a_no_read_while_clearing : assert property (@(posedge clk) disable iff (rst)
    clearing |-> !rd_en && !wr_en)
    else $error("degree store accessed during the clearing sweep");

  a_sweep_covers_store : assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == LAST_ADDR)
    else $error("clearing sweep ended before the last entry");

endmodule

// File: hdl/cicb_stream_ctrl.sv
module cicb_stream_ctrl #(
  parameter int MAX_VERTICES = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cicb_pkg::in_item_t                in_data,
  input  logic [16:0]                       num_vertices,
  input  logic                              mem_busy,
  output logic                              rd_en,
  output logic [$clog2(MAX_VERTICES)-1:0]   rd_addr,
  input  logic [31:0]                       rd_data,
  output logic                              wr_en,
  output logic [$clog2(MAX_VERTICES)-1:0]   wr_addr,
  output logic [31:0]                       wr_data,
  input  logic                              emit_can_load,
  output logic                              emit_load,
  output cicb_pkg::bundle_t                 bundle
);

  import cicb_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam logic [31:0] MAX32 = 32'(MAX_VERTICES);

  logic          s1_valid;
  in_item_t      s1_item;
  logic          s1_adv;
  logic          edge_ok;

  // Stream state.
  logic [NW-1:0] next_dest;
  logic          have_current;
  logic [AW-1:0] current_dest;
  logic [NW-1:0] current_count;
  logic          have_previous;
  logic [AW-1:0] previous_source;
  logic [AW-1:0] previous_dest;

  logic [NW-1:0] next_dest_next;
  logic          have_current_next;
  logic [AW-1:0] current_dest_next;
  logic [NW-1:0] current_count_next;
  logic          have_previous_next;
  logic [AW-1:0] previous_source_next;
  logic [AW-1:0] previous_dest_next;

  logic [NW-1:0] vb;
  logic [31:0]   vb32;
  logic [31:0]   src;
  logic [31:0]   dst;
  logic [31:0]   prev_s32;
  logic [31:0]   prev_d32;
  logic [NW-1:0] nd1;
  logic [31:0]   nd1_32;
  logic          order_bad;
  logic          dst_bad;
  logic          src_bad;
  logic          deg_full;
  logic          new_dest;

  // Input stage: the degree read is issued as the transaction is accepted.
  assign in_ready = !mem_busy && (!s1_valid || s1_adv);
  assign rd_en    = in_valid && in_ready;
  assign rd_addr  = in_data.edge_source[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_item <= in_data;
    end
  end

  // Effective vertex bound and the checks on the held transaction.
  always_comb begin
    vb        = (32'(num_vertices) > MAX32) ? NW'(MAX_VERTICES) : NW'(num_vertices);
    vb32      = 32'(vb);
    src       = s1_item.edge_source;
    dst       = s1_item.edge_destination;
    prev_s32  = 32'(previous_source);
    prev_d32  = 32'(previous_dest);
    order_bad = have_previous &&
                !(prev_d32 < dst || (prev_d32 == dst && prev_s32 < src));
    dst_bad   = dst >= vb32;
    src_bad   = src >= vb32;
    deg_full  = rd_data == 32'hFFFF_FFFF;
    nd1       = have_current ? next_dest + NW'(1) : next_dest;
    nd1_32    = 32'(nd1);
    new_dest  = !have_current || dst != 32'(current_dest);
  end

  // Results and next state of the held transaction.
  always_comb begin
    bundle               = '0;
    edge_ok              = 1'b0;
    next_dest_next       = next_dest;
    have_current_next    = have_current;
    current_dest_next    = current_dest;
    current_count_next   = current_count;
    have_previous_next   = have_previous;
    previous_source_next = previous_source;
    previous_dest_next   = previous_dest;
    unique case (s1_item.func)
      FUNC_EDGE: begin
        if (order_bad) begin
          bundle.mask[0] = 1'b1;
          bundle.slot[0] = make_result(KIND_ERROR, '0, '0, '0, ERR_ORDER);
        end else if (dst_bad) begin
          bundle.mask[0] = 1'b1;
          bundle.slot[0] = make_result(KIND_ERROR, '0, '0, '0, ERR_DEST_RANGE);
        end else if (src_bad) begin
          bundle.mask[0] = 1'b1;
          bundle.slot[0] = make_result(KIND_ERROR, '0, '0, '0, ERR_SRC_RANGE);
        end else if (deg_full) begin
          bundle.mask[0] = 1'b1;
          bundle.slot[0] = make_result(KIND_ERROR, '0, '0, '0, ERR_DEGREE_OVF);
        end else begin
          edge_ok              = 1'b1;
          have_previous_next   = 1'b1;
          previous_source_next = src[AW-1:0];
          previous_dest_next   = dst[AW-1:0];
          current_count_next   = current_count + NW'(1);
          if (new_dest) begin
            // Close the finished destination and any skipped ones.
            bundle.mask[0] = have_current;
            bundle.slot[0] = make_result(KIND_COUNT, 32'(next_dest), 32'(current_count),
                                         32'd1, ERR_NONE);
            if (nd1_32 < dst) begin
              bundle.mask[1] = 1'b1;
              bundle.slot[1] = make_result(KIND_COUNT, nd1_32, '0, dst - nd1_32, ERR_NONE);
            end
            next_dest_next     = (nd1_32 < dst) ? dst[NW-1:0] : nd1;
            have_current_next  = 1'b1;
            current_dest_next  = dst[AW-1:0];
            current_count_next = NW'(1);
          end
          bundle.mask[2] = 1'b1;
          bundle.slot[2] = make_result(KIND_SOURCE, dst, src, '0, ERR_NONE);
        end
      end
      FUNC_FINISH: begin
        bundle.mask[0] = have_current;
        bundle.slot[0] = make_result(KIND_COUNT, 32'(next_dest), 32'(current_count),
                                     32'd1, ERR_NONE);
        if (nd1 < vb) begin
          bundle.mask[1] = 1'b1;
          bundle.slot[1] = make_result(KIND_COUNT, nd1_32, '0, vb32 - nd1_32, ERR_NONE);
        end
        next_dest_next       = '0;
        have_current_next    = 1'b0;
        current_dest_next    = '0;
        current_count_next   = '0;
        have_previous_next   = 1'b0;
        previous_source_next = '0;
        previous_dest_next   = '0;
      end
      FUNC_READ: begin
        if (src_bad) begin
          bundle.mask[0] = 1'b1;
          bundle.slot[0] = make_result(KIND_ERROR, '0, '0, '0, ERR_SRC_RANGE);
        end else begin
          bundle.mask[2] = 1'b1;
          bundle.slot[2] = make_result(KIND_DEGREE, src, rd_data, '0, ERR_NONE);
        end
      end
      default: begin
      end
    endcase
  end

  // The held transaction moves on once its results have somewhere to go.
  assign s1_adv    = s1_valid && (bundle.mask == '0 || emit_can_load);
  assign emit_load = s1_adv && (bundle.mask != '0);

  // Out-degree increment written back as the edge retires.
  assign wr_en   = s1_adv && edge_ok;
  assign wr_addr = s1_item.edge_source[AW-1:0];
  assign wr_data = rd_data + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_dest       <= '0;
      have_current    <= 1'b0;
      current_dest    <= '0;
      current_count   <= '0;
      have_previous   <= 1'b0;
      previous_source <= '0;
      previous_dest   <= '0;
    end else if (s1_adv) begin
      next_dest       <= next_dest_next;
      have_current    <= have_current_next;
      current_dest    <= current_dest_next;
      current_count   <= current_count_next;
      have_previous   <= have_previous_next;
      previous_source <= previous_source_next;
      previous_dest   <= previous_dest_next;
    end
  end

  a_open_dest_is_next : assert property (@(posedge clk) disable iff (rst)
    have_current |-> next_dest == NW'(current_dest) && previous_dest == current_dest)
    else $error("open destination differs from the count position");

  a_finish_clears : assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_item.func == FUNC_FINISH |=>
      next_dest == '0 && !have_current && !have_previous)
    else $error("stream state not cleared after finish");

endmodule

// File: hdl/cicb_result_emit.sv
module cicb_result_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  cicb_pkg::bundle_t   bundle,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output cicb_pkg::out_item_t out_data
);

  import cicb_pkg::*;

  logic [NUM_SLOTS-1:0]      mask;
  out_item_t [NUM_SLOTS-1:0] slots;
  logic [NUM_SLOTS-1:0]      sel;
  logic [NUM_SLOTS-1:0]      rest;

  // Lowest pending slot goes out first.
  assign sel  = mask & ~(mask - NUM_SLOTS'(1));
  assign rest = mask & ~sel;

  always_comb begin
    out_data = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sel[i]) begin
        out_data = slots[i];
      end
    end
    out_data.last = (rest == '0);
  end

  assign out_valid = (mask != '0);
  assign can_load  = (mask == '0) || (out_ready && rest == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= bundle.mask;
    end else if (out_valid && out_ready) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= bundle.slot;
    end
  end

  a_error_is_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_ERROR |-> out_data.last)
    else $error("error result not marked last");

endmodule

// File: hdl/csr_incoming_count_builder_unit.sv
// Incoming-count builder for a compressed sparse row graph. It takes deduplicated edges
// sorted by destination then source, passes each source through as a record, emits one
// incoming count per destination (with skipped destinations as one zero-count run) and
// keeps an out-degree per vertex in an on-chip memory of MAX_VERTICES words. A finish
// transaction flushes and pads to num_vertices, capped at MAX_VERTICES; a read
// transaction returns one degree. Each accepted transaction is held in a register while
// its degree read completes; its results then go into the output register. An edge costs
// one read-modify-write of the degree memory, forwarded so that a new edge can be taken
// every cycle while the output side can take its results; the rate is then set by the
// single output channel, which carries one result per cycle while out_ready is high,
// at most three per transaction. After reset the degree memory is cleared one word per
// cycle with in_ready held low; num_vertices may be written during that time.
module csr_incoming_count_builder_unit #(
  parameter int MAX_VERTICES = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cicb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cicb_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [16:0]         cfg_wr_data
);

  import cicb_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  logic [16:0]   num_vertices;
  logic          mem_busy;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          emit_can_load;
  logic          emit_load;
  bundle_t       bundle;

  // Vertex count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices <= 17'd1;
    end else if (cfg_wr_en) begin
      num_vertices <= cfg_wr_data;
    end
  end

  cicb_degree_mem #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_degree_mem (
    .clk     (clk),
    .rst     (rst),
    .busy    (mem_busy),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  cicb_stream_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_stream_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .num_vertices  (num_vertices),
    .mem_busy      (mem_busy),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .emit_can_load (emit_can_load),
    .emit_load     (emit_load),
    .bundle        (bundle)
  );

  cicb_result_emit u_result_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (emit_load),
    .bundle    (bundle),
    .can_load  (emit_can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: tb/csr_incoming_count_builder_unit_tb.sv
module csr_incoming_count_builder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cicb_pkg::*;

  localparam int MAX_V          = 65536;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_ITEMS    = 30;

  // Function code that the block ignores.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // One row of the directed table: a register write, or a transaction with its
  // results either typed in (n_typed 0 or 1) or left to the predictor (n_typed -1).
  typedef struct {
    bit          is_cfg;
    logic [16:0] cfg_value;
    in_item_t    item;
    int          n_typed;
    out_item_t   typed;
  } row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en = 1'b0;
  logic [16:0] cfg_wr_data = '0;

  // Idling controls, set by the stimulus process for each phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int mismatches     = 0;

  // Predictor copy of the register and of the stream state.
  bit [16:0] vcount_cfg = 17'd1;
  bit [31:0] count_cursor;
  bit        dest_open;
  bit [31:0] open_dest;
  bit [31:0] open_count;
  bit        edge_seen;
  bit [31:0] last_src;
  bit [31:0] last_dst;
  bit [31:0] deg_count [MAX_V];

  // Results still to arrive, oldest first.
  out_item_t csr_results_due[$];
  out_item_t due_head;

  csr_incoming_count_builder_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_CYCLES * 12);
    $display("** csr_incoming_count_builder_unit: FAILED **");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // The register value clamped to the size of the degree memory.
  function automatic logic [31:0] eff_bound();
    return (vcount_cfg > MAX_V) ? MAX_V : vcount_cfg;
  endfunction

  task automatic add_result(input logic [1:0] kind, input logic [31:0] idx,
                            input logic [31:0] val, input logic [31:0] run,
                            input logic [2:0] err);
    out_item_t r;
    r.kind         = kind;
    r.vertex_index = idx[15:0];
    r.value        = val;
    r.run_length   = run[16:0];
    r.err_code     = err;
    r.last         = 1'b0;
    csr_results_due.push_back(r);
  endtask

  // Emits the count of the destination that is still open, if any.
  task automatic close_open_dest();
    if (dest_open) begin
      add_result(KIND_COUNT, count_cursor, open_count, 32'd1, ERR_NONE);
      count_cursor++;
    end
  endtask

  // Works out every result of one accepted transaction and updates the state.
  task automatic predict_csr_results(input in_item_t it);
    logic [31:0] vb;
    logic [31:0] src;
    logic [31:0] dst;
    int          before_n;
    out_item_t   tail;
    vb       = eff_bound();
    src      = it.edge_source;
    dst      = it.edge_destination;
    before_n = csr_results_due.size();
    case (it.func)
      FUNC_EDGE: begin
        if (edge_seen && !(last_dst < dst || (last_dst == dst && last_src < src)))
          add_result(KIND_ERROR, 0, 0, 0, ERR_ORDER);
        else if (dst >= vb)
          add_result(KIND_ERROR, 0, 0, 0, ERR_DEST_RANGE);
        else if (src >= vb)
          add_result(KIND_ERROR, 0, 0, 0, ERR_SRC_RANGE);
        else if (deg_count[src[15:0]] == 32'hFFFF_FFFF)
          add_result(KIND_ERROR, 0, 0, 0, ERR_DEGREE_OVF);
        else begin
          edge_seen = 1'b1;
          last_src  = src;
          last_dst  = dst;
          if (!dest_open || dst != open_dest) begin
            close_open_dest();
            if (count_cursor < dst) begin
              add_result(KIND_COUNT, count_cursor, 0, dst - count_cursor, ERR_NONE);
              count_cursor = dst;
            end
            dest_open  = 1'b1;
            open_dest  = dst;
            open_count = 0;
          end
          add_result(KIND_SOURCE, dst, src, 0, ERR_NONE);
          deg_count[src[15:0]]++;
          open_count++;
        end
      end
      FUNC_FINISH: begin
        close_open_dest();
        if (count_cursor < vb)
          add_result(KIND_COUNT, count_cursor, 0, vb - count_cursor, ERR_NONE);
        count_cursor = 0;
        dest_open    = 1'b0;
        open_dest    = 0;
        open_count   = 0;
        edge_seen    = 1'b0;
        last_src     = 0;
        last_dst     = 0;
      end
      FUNC_READ: begin
        if (src >= vb) add_result(KIND_ERROR, 0, 0, 0, ERR_SRC_RANGE);
        else add_result(KIND_DEGREE, src, deg_count[src[15:0]], 0, ERR_NONE);
      end
      default: begin
      end
    endcase
    // Mark the final result of this transaction.
    if (csr_results_due.size() > before_n) begin
      tail      = csr_results_due.pop_back();
      tail.last = 1'b1;
      csr_results_due.push_back(tail);
    end
  endtask

  // Offers one transaction, after a random idle gap, and returns once it is taken.
  task automatic send_txn(input in_item_t it);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every expected result has come, then lets the pipeline settle.
  task automatic wait_drained();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (csr_results_due.size() > 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    if (csr_results_due.size() > 0) begin
      note_mismatch($sformatf("%0d expected results never arrived",
                              csr_results_due.size()));
      csr_results_due.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_vertex_count(input logic [16:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    vcount_cfg = v;
  endtask

  // Picks an id in [lo, hi], mostly close to lo.
  function automatic logic [31:0] pick_id(input logic [31:0] lo, input logic [31:0] hi);
    if (hi - lo > 3 && $urandom_range(99) < 30) return $urandom_range(hi, lo);
    return lo + $urandom_range((hi - lo > 3) ? 3 : hi - lo, 0);
  endfunction

  // Random transaction: mostly the next edge of a well-formed stream, with finishes,
  // reads, broken edges and the odd ignored code mixed in.
  task automatic next_random_txn(output in_item_t it);
    int          r;
    logic [31:0] vb;
    vb = eff_bound();
    r  = $urandom_range(99);
    it.func             = FUNC_EDGE;
    it.edge_source      = $urandom;
    it.edge_destination = $urandom;
    if (r < 72) begin
      if (!edge_seen) begin
        it.edge_destination = pick_id(0, vb - 1);
        it.edge_source      = pick_id(0, vb - 1);
      end else if (last_src + 1 < vb && (last_dst + 1 >= vb || $urandom_range(1) == 1)) begin
        it.edge_destination = last_dst;
        it.edge_source      = pick_id(last_src + 1, vb - 1);
      end else if (last_dst + 1 < vb) begin
        it.edge_destination = pick_id(last_dst + 1, vb - 1);
        it.edge_source      = pick_id(0, vb - 1);
      end else begin
        it.func = FUNC_FINISH;
      end
    end else if (r < 80) begin
      it.func = FUNC_FINISH;
    end else if (r < 89) begin
      it.func = FUNC_READ;
      if ($urandom_range(99) < 80) it.edge_source = pick_id(0, vb - 1);
    end else if (r < 97) begin
      // Broken edge: fully random ids, a step backwards, or an id just out of range.
      case ($urandom_range(2))
        0: begin
        end
        1: begin
          it.edge_destination = last_dst - $urandom_range(1, 0);
          it.edge_source      = last_src;
        end
        default: begin
          if ($urandom_range(1) == 1) begin
            it.edge_destination = vb + $urandom_range(2, 0);
            it.edge_source      = pick_id(0, vb - 1);
          end else begin
            it.edge_destination = last_dst + 1;
            it.edge_source      = vb + $urandom_range(2, 0);
          end
        end
      endcase
    end else begin
      it.func = FUNC_UNUSED;
    end
  endtask

  function automatic out_item_t error_of(input logic [2:0] code);
    return out_item_t'{KIND_ERROR, 16'd0, 32'd0, 17'd0, code, 1'b1};
  endfunction

  function automatic row_t cfg_row(input logic [16:0] v);
    row_t r;
    r           = '{default: '0};
    r.is_cfg    = 1'b1;
    r.cfg_value = v;
    return r;
  endfunction

  function automatic row_t txn_row(input logic [1:0] f, input logic [31:0] src,
                                   input logic [31:0] dst);
    row_t r;
    r         = '{default: '0};
    r.item    = in_item_t'{f, src, dst};
    r.n_typed = -1;
    return r;
  endfunction

  function automatic row_t err_row(input logic [1:0] f, input logic [31:0] src,
                                   input logic [31:0] dst, input logic [2:0] code);
    row_t r;
    r         = txn_row(f, src, dst);
    r.n_typed = 1;
    r.typed   = error_of(code);
    return r;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (csr_results_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result %p", out_data));
      end else begin
        due_head = csr_results_due.pop_front();
        if (out_data.kind !== due_head.kind)
          note_mismatch($sformatf("kind %0d, expected %0d", out_data.kind, due_head.kind));
        if (out_data.vertex_index !== due_head.vertex_index)
          note_mismatch($sformatf("vertex_index %0d, expected %0d",
                                  out_data.vertex_index, due_head.vertex_index));
        if (out_data.value !== due_head.value)
          note_mismatch($sformatf("value %0d, expected %0d", out_data.value, due_head.value));
        if (out_data.run_length !== due_head.run_length)
          note_mismatch($sformatf("run_length %0d, expected %0d",
                                  out_data.run_length, due_head.run_length));
        if (out_data.err_code !== due_head.err_code)
          note_mismatch($sformatf("err_code %0d, expected %0d",
                                  out_data.err_code, due_head.err_code));
        if (out_data.last !== due_head.last)
          note_mismatch($sformatf("last %0b, expected %0b", out_data.last, due_head.last));
      end
    end
  end

  // Stimulus: directed table, then random phases with different idling.
  initial begin
    row_t        rows[$];
    row_t        r;
    in_item_t    it;
    int          i;
    int          p;
    int          k;
    logic [16:0] phase_vc[NUM_PHASES];
    int          phase_send[NUM_PHASES];
    int          phase_recv[NUM_PHASES];

    phase_vc   = '{17'd8, 17'd5, 17'd16, 17'd65536, 17'd3, 17'd131071};
    phase_send = '{0, 54, 0, 27, 0, 0};
    phase_recv = '{0, 0, 54, 27, 0, 54};

    // Reads against the reset value of the register.
    r         = txn_row(FUNC_READ, 32'd0, 32'd0);
    r.n_typed = 1;
    r.typed   = out_item_t'{KIND_DEGREE, 16'd0, 32'd0, 17'd0, ERR_NONE, 1'b1};
    rows.push_back(r);
    rows.push_back(err_row(FUNC_READ, 32'd1, 32'd0, ERR_SRC_RANGE));
    // A small graph: repeats, backward steps, skipped destinations, range errors.
    rows.push_back(cfg_row(17'd6));
    rows.push_back(txn_row(FUNC_EDGE, 32'd1, 32'd0));
    rows.push_back(err_row(FUNC_EDGE, 32'd1, 32'd0, ERR_ORDER));
    rows.push_back(err_row(FUNC_EDGE, 32'd0, 32'd0, ERR_ORDER));
    rows.push_back(txn_row(FUNC_EDGE, 32'd4, 32'd0));
    rows.push_back(txn_row(FUNC_EDGE, 32'd2, 32'd3));
    rows.push_back(err_row(FUNC_EDGE, 32'd0, 32'd6, ERR_DEST_RANGE));
    rows.push_back(err_row(FUNC_EDGE, 32'd0, 32'hFFFF_FFFF, ERR_DEST_RANGE));
    rows.push_back(err_row(FUNC_EDGE, 32'hFFFF_FFFF, 32'd4, ERR_SRC_RANGE));
    rows.push_back(err_row(FUNC_EDGE, 32'd6, 32'd4, ERR_SRC_RANGE));
    rows.push_back(txn_row(FUNC_EDGE, 32'd5, 32'd4));
    r         = txn_row(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    r.n_typed = 0;
    rows.push_back(r);
    rows.push_back(txn_row(FUNC_READ, 32'd5, 32'd0));
    rows.push_back(err_row(FUNC_READ, 32'hFFFF_FFFF, 32'd0, ERR_SRC_RANGE));
    rows.push_back(txn_row(FUNC_FINISH, 32'd0, 32'd0));
    rows.push_back(txn_row(FUNC_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    rows.push_back(txn_row(FUNC_READ, 32'd1, 32'd0));
    // No vertices at all: everything out of range, and a finish with nothing to do.
    rows.push_back(cfg_row(17'd0));
    rows.push_back(err_row(FUNC_EDGE, 32'd0, 32'd0, ERR_DEST_RANGE));
    rows.push_back(err_row(FUNC_READ, 32'd0, 32'd0, ERR_SRC_RANGE));
    r         = txn_row(FUNC_FINISH, 32'd0, 32'd0);
    r.n_typed = 0;
    rows.push_back(r);
    // Register above the memory size: the top vertex and a long zero run.
    rows.push_back(cfg_row(17'h1FFFF));
    rows.push_back(txn_row(FUNC_EDGE, 32'd65535, 32'd65535));
    rows.push_back(err_row(FUNC_EDGE, 32'hFFFF_FFFF, 32'd65535, ERR_SRC_RANGE));
    rows.push_back(txn_row(FUNC_FINISH, 32'd0, 32'd0));
    rows.push_back(txn_row(FUNC_READ, 32'd65535, 32'd0));
    // A single vertex.
    rows.push_back(cfg_row(17'd1));
    rows.push_back(txn_row(FUNC_EDGE, 32'd0, 32'd0));
    rows.push_back(txn_row(FUNC_FINISH, 32'd0, 32'd0));
    rows.push_back(txn_row(FUNC_READ, 32'd0, 32'd0));

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < rows.size(); i++) begin
      if (rows[i].is_cfg) begin
        wait_drained();
        write_vertex_count(rows[i].cfg_value);
      end else begin
        send_txn(rows[i].item);
        if (rows[i].n_typed < 0) predict_csr_results(rows[i].item);
        else if (rows[i].n_typed > 0) csr_results_due.push_back(rows[i].typed);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_vertex_count(phase_vc[p]);
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      // The first phase runs at full input rate against a long output hold-off.
      if (p == 0) hold_req = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        next_random_txn(it);
        send_txn(it);
        predict_csr_results(it);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("** csr_incoming_count_builder_unit: PASSED **");
    end else begin
      $display("** csr_incoming_count_builder_unit: FAILED **");
    end
    $finish;
  end

endmodule
